/* design/mrmq_pkg.sv */
// ----------------------------------------------------------------------------
// mrmq_pkg
// Shared types and codes for the multi-ring message queue unit.
// ----------------------------------------------------------------------------
package mrmq_pkg;

	localparam logic [2:0] MODE_CREATE  = 3'd0;
	localparam logic [2:0] MODE_SEND    = 3'd1;
	localparam logic [2:0] MODE_JAM     = 3'd2;
	localparam logic [2:0] MODE_RECV    = 3'd3;
	localparam logic [2:0] MODE_DESTROY = 3'd4;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_DENIED  = 3'd2;
	localparam logic [2:0] ST_NOFREE  = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;
	localparam logic [2:0] ST_EMPTY   = 3'd5;
	localparam logic [2:0] ST_BLOCK   = 3'd6;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic finish;
	} ctrl_t;

	// datapath -> controller
	typedef struct packed {
		logic need_read;
	} stat_t;

endpackage

/* design/mrmq_ram.sv */
// ----------------------------------------------------------------------------
// mrmq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mrmq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* design/mrmq_ctrl.sv */
// ----------------------------------------------------------------------------
// mrmq_ctrl
// Sequencer: capture, execute, optional store read, then report.
// ----------------------------------------------------------------------------
module mrmq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  mrmq_pkg::stat_t       stat,
	output logic                  busy,
	output mrmq_pkg::ctrl_t       ctrl
);

	mrmq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrmq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mrmq_pkg::S_IDLE: if (start) state_d = mrmq_pkg::S_EXEC;
			mrmq_pkg::S_EXEC: state_d = stat.need_read ? mrmq_pkg::S_READ : mrmq_pkg::S_IDLE;
			mrmq_pkg::S_READ: state_d = mrmq_pkg::S_IDLE;
			default:          state_d = mrmq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		busy = 1'b0;
		ctrl = '0;
		case (state_q)
			mrmq_pkg::S_IDLE: begin
				ctrl.capture = start;
			end
			mrmq_pkg::S_EXEC: begin
				busy        = 1'b1;
				ctrl.exec   = 1'b1;
				ctrl.finish = !stat.need_read;
			end
			mrmq_pkg::S_READ: begin
				busy        = 1'b1;
				ctrl.finish = 1'b1;
			end
			default: busy = 1'b0;
		endcase
	end

endmodule

/* design/mrmq_dp.sv */
// ----------------------------------------------------------------------------
// mrmq_dp
// Per-queue state registers, ring address math and the shared word store.
// ----------------------------------------------------------------------------
module mrmq_dp #(
	parameter int NUM_QUEUES  = 16,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  mrmq_pkg::ctrl_t ctrl,
	output mrmq_pkg::stat_t stat,
	input  logic [2:0]      mode,
	input  logic [3:0]      queue_sel,
	input  logic [3:0]      process_id,
	input  logic [31:0]     message_in,
	input  logic [4:0]      size_req,
	input  logic            no_wait,
	output logic            done,
	output logic [2:0]      status,
	output logic [31:0]     message_out,
	output logic [3:0]      queue_id_out
);

	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH) > 0 ?
		$clog2(NUM_QUEUES * QUEUE_DEPTH) : 1;

	logic [CW-1:0] cap_q   [NUM_QUEUES];
	logic [CW-1:0] used_q  [NUM_QUEUES];
	logic [PW-1:0] head_q  [NUM_QUEUES];
	logic [3:0]    owner_q [NUM_QUEUES];

	logic [2:0]  mode_q;
	logic [3:0]  qsel_q;
	logic [3:0]  pid_q;
	logic [31:0] msg_q;
	logic [4:0]  size_q;
	logic        nowait_q;
	logic [2:0]  status_q;
	logic [3:0]  idout_q;
	logic        rd_q;

	function automatic logic [2:0] no_wait_sel(input logic nw, input logic [2:0] code);
		return nw ? code : mrmq_pkg::ST_BLOCK;
	endfunction

	// lowest free queue
	logic          free_found;
	logic [QW-1:0] free_idx;
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int k = NUM_QUEUES - 1; k >= 0; k--) begin
			if (cap_q[k] == '0) begin
				free_found = 1'b1;
				free_idx   = QW'(k);
			end
		end
	end

	logic          q_ok;
	logic [QW-1:0] qi;
	logic [CW-1:0] cap, used;
	logic [PW-1:0] head;
	logic [CW:0]   pos_sum;
	logic [PW-1:0] tail_pos, jam_pos, nxt_head;
	logic          full, empty, size_ok;
	logic [2:0]    st;
	logic          wr, do_recv, do_send, do_jam, do_create, do_destroy;

	always_comb begin
		q_ok     = ({28'd0, qsel_q} < 32'(NUM_QUEUES));
		qi       = QW'(qsel_q);
		cap      = cap_q[qi];
		used     = used_q[qi];
		head     = head_q[qi];
		pos_sum  = {1'b0, CW'(head)} + {1'b0, used};
		if (pos_sum >= {1'b0, cap}) pos_sum = pos_sum - {1'b0, cap};
		tail_pos = PW'(pos_sum);
		jam_pos  = (head == '0) ? PW'(cap - CW'(1)) : head - PW'(1);
		nxt_head = ({1'b0, CW'(head)} + 1'b1 >= {1'b0, cap}) ? '0 : head + PW'(1);
		full     = cap <= used;
		empty    = (used == '0) || (cap == '0);
		size_ok  = (size_q != 5'd0) && ({27'd0, size_q} <= 32'(QUEUE_DEPTH));
		st = mrmq_pkg::ST_OK;
		do_send = 1'b0; do_jam = 1'b0; do_recv = 1'b0;
		do_create = 1'b0; do_destroy = 1'b0;
		if (mode_q == mrmq_pkg::MODE_CREATE) begin
			if (!size_ok) st = mrmq_pkg::ST_INVALID;
			else if (!free_found) st = mrmq_pkg::ST_NOFREE;
			else do_create = 1'b1;
		end else if (mode_q > mrmq_pkg::MODE_DESTROY || !q_ok) begin
			st = mrmq_pkg::ST_INVALID;
		end else if (owner_q[qi] != pid_q) begin
			st = mrmq_pkg::ST_DENIED;
		end else begin
			case (mode_q)
				mrmq_pkg::MODE_SEND, mrmq_pkg::MODE_JAM: begin
					if (full) st = no_wait_sel(nowait_q, mrmq_pkg::ST_FULL);
					else if (mode_q == mrmq_pkg::MODE_SEND) do_send = 1'b1;
					else do_jam = 1'b1;
				end
				mrmq_pkg::MODE_RECV: begin
					if (empty) st = no_wait_sel(nowait_q, mrmq_pkg::ST_EMPTY);
					else do_recv = 1'b1;
				end
				default: do_destroy = 1'b1;
			endcase
		end
		wr = ctrl.exec && (do_send || do_jam);
	end

	assign stat.need_read = do_recv;

	logic [AW-1:0] waddr, raddr;
	logic [31:0]   rdata;
	logic [AW-1:0] base;
	assign base  = AW'(qi) * AW'(QUEUE_DEPTH);
	assign waddr = base + AW'(do_send ? tail_pos : jam_pos);
	assign raddr = base + AW'(head);

	mrmq_ram #(.WIDTH(32), .DEPTH(NUM_QUEUES * QUEUE_DEPTH)) u_store (
		.clk   (clk),
		.we    (wr),
		.waddr (waddr),
		.wdata (msg_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			mode_q   <= mode;
			qsel_q   <= queue_sel;
			pid_q    <= process_id;
			msg_q    <= message_in;
			size_q   <= size_req;
			nowait_q <= no_wait;
		end
		if (ctrl.exec) begin
			status_q <= st;
			idout_q  <= do_create ? 4'(free_idx) : 4'd0;
			rd_q     <= do_recv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_QUEUES; k++) begin
				cap_q[k]   <= '0;
				used_q[k]  <= '0;
				head_q[k]  <= '0;
				owner_q[k] <= '0;
			end
		end else if (ctrl.exec) begin
			if (do_create) begin
				cap_q[free_idx]   <= CW'(size_q);
				used_q[free_idx]  <= '0;
				head_q[free_idx]  <= '0;
				owner_q[free_idx] <= pid_q;
			end
			if (do_send) used_q[qi] <= used + CW'(1);
			if (do_jam) begin
				used_q[qi] <= used + CW'(1);
				head_q[qi] <= jam_pos;
			end
			if (do_recv) begin
				used_q[qi] <= used - CW'(1);
				head_q[qi] <= nxt_head;
			end
			if (do_destroy) cap_q[qi] <= '0;
		end
	end

	// results: exec cycle gives status from st, read cycle from latched regs
	assign done         = ctrl.finish;
	assign status       = ctrl.exec ? st : status_q;
	assign queue_id_out = ctrl.exec ? (do_create ? 4'(free_idx) : 4'd0) : idout_q;
	assign message_out  = (!ctrl.exec && rd_q) ? rdata : 32'd0;

endmodule

/* design/multi_ring_message_queue_unit.sv */
// ----------------------------------------------------------------------------
// multi_ring_message_queue_unit
// Pool of circular message queues sharing one word store.
// ----------------------------------------------------------------------------
// Result strobe: done comes in the cycle after start is taken; a successful
// receive goes on through a read state, which waits on the registered store
// read. A new item is taken only once the last one is through (busy is high).
// Reset clears all queue state (all queues free); store contents stay unset.
// The receiver cannot stall: done is a one-cycle strobe.
module multi_ring_message_queue_unit #(
	parameter int NUM_QUEUES  = 16,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [3:0]  queue_sel,
	input  logic [3:0]  process_id,
	input  logic [31:0] message_in,
	input  logic [4:0]  size_req,
	input  logic        no_wait,
	output logic        done,
	output logic [2:0]  status,
	output logic [31:0] message_out,
	output logic [3:0]  queue_id_out
);

	mrmq_pkg::ctrl_t ctrl;
	mrmq_pkg::stat_t stat;

	mrmq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	mrmq_dp #(.NUM_QUEUES(NUM_QUEUES), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.stat         (stat),
		.mode         (mode),
		.queue_sel    (queue_sel),
		.process_id   (process_id),
		.message_in   (message_in),
		.size_req     (size_req),
		.no_wait      (no_wait),
		.done         (done),
		.status       (status),
		.message_out  (message_out),
		.queue_id_out (queue_id_out)
	);

endmodule

/* tb/sv/tb_multi_ring_message_queue_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_ring_message_queue_unit
// Drives create/send/jam/receive/destroy items into the queue pool, predicts
// each status result with a local queue-pool model and compares in order.
// ----------------------------------------------------------------------------
module tb_multi_ring_message_queue_unit;

	localparam int NQ = 16;
	localparam int QD = 16;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [2:0]  st;
		logic [31:0] msg;
		logic [3:0]  qid;
	} qresult_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  mode;
	logic [3:0]  queue_sel;
	logic [3:0]  process_id;
	logic [31:0] message_in;
	logic [4:0]  size_req;
	logic        no_wait;
	logic        done;
	logic [2:0]  status;
	logic [31:0] message_out;
	logic [3:0]  queue_id_out;

	multi_ring_message_queue_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mode(mode), .queue_sel(queue_sel), .process_id(process_id),
		.message_in(message_in), .size_req(size_req), .no_wait(no_wait),
		.done(done), .status(status), .message_out(message_out),
		.queue_id_out(queue_id_out)
	);

	// predictor state
	logic [4:0]  pool_cap [NQ];
	logic [3:0]  pool_head [NQ];
	logic [4:0]  pool_used [NQ];
	logic [3:0]  pool_owner [NQ];
	logic [31:0] ring_words [NQ*QD];

	qresult_t pending_results [$];
	int mismatches = 0;
	int idle_pct = 0;
	int watchdog = 0;
	bit timed_out = 0;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic qresult_t predict_queue_op(logic [2:0] m, logic [3:0] q, logic [3:0] p,
			logic [31:0] w, logic [4:0] sz, logic nw);
		qresult_t r;
		int k;
		logic [4:0] pos;
		r = '0;
		r.st = mrmq_pkg::ST_OK;
		if (m == mrmq_pkg::MODE_CREATE) begin
			if (sz == 0 || sz > QD) begin
				r.st = mrmq_pkg::ST_INVALID;
			end else begin
				k = 0;
				while (k < NQ && pool_cap[k] != 0) k++;
				if (k >= NQ) begin
					r.st = mrmq_pkg::ST_NOFREE;
				end else begin
					pool_cap[k] = sz;
					pool_used[k] = 0;
					pool_head[k] = 0;
					pool_owner[k] = p;
					r.qid = k[3:0];
				end
			end
		end else if (m > mrmq_pkg::MODE_DESTROY) begin
			r.st = mrmq_pkg::ST_INVALID;
		end else if (pool_owner[q] != p) begin
			r.st = mrmq_pkg::ST_DENIED;
		end else if (m == mrmq_pkg::MODE_SEND || m == mrmq_pkg::MODE_JAM) begin
			if (pool_cap[q] <= pool_used[q]) begin
				r.st = nw ? mrmq_pkg::ST_FULL : mrmq_pkg::ST_BLOCK;
			end else if (m == mrmq_pkg::MODE_SEND) begin
				pos = pool_head[q] + pool_used[q];
				if (pos >= pool_cap[q]) pos = pos - pool_cap[q];
				ring_words[q*QD + pos] = w;
				pool_used[q]++;
			end else begin
				pool_head[q] = (pool_head[q] == 0) ? 4'(pool_cap[q] - 1) : pool_head[q] - 4'd1;
				ring_words[q*QD + pool_head[q]] = w;
				pool_used[q]++;
			end
		end else if (m == mrmq_pkg::MODE_RECV) begin
			if (pool_used[q] == 0 || pool_cap[q] == 0) begin
				r.st = nw ? mrmq_pkg::ST_EMPTY : mrmq_pkg::ST_BLOCK;
			end else begin
				r.msg = ring_words[q*QD + pool_head[q]];
				pos = pool_head[q] + 1;
				if (pos >= pool_cap[q]) pos = pos - pool_cap[q];
				pool_head[q] = pos[3:0];
				pool_used[q]--;
			end
		end else begin
			pool_cap[q] = 0;
		end
		return r;
	endfunction

	// start stays high between items but for idle gaps; busy is settled by the falling edge
	task automatic send_item(logic [2:0] m, logic [3:0] q, logic [3:0] p,
			logic [31:0] w, logic [4:0] sz, logic nw);
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		mode <= m;
		queue_sel <= q;
		process_id <= p;
		message_in <= w;
		size_req <= sz;
		no_wait <= nw;
		do @(negedge clk); while (busy);
		@(posedge clk);
		pending_results.push_back(predict_queue_op(m, q, p, w, sz, nw));
	endtask

	task automatic drain_results();
		start <= 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		qresult_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result st=%0d", status);
			end else begin
				e = pending_results.pop_front();
				if (status !== e.st || message_out !== e.msg || queue_id_out !== e.qid) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp st=%0d msg=%h id=%0d got st=%0d msg=%h id=%0d",
							e.st, e.msg, e.qid, status, message_out, queue_id_out);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (done || (start && !busy)) watchdog <= 0;
		else watchdog <= watchdog + 1;
	end

	// live pid of a queue so most random items pass the owner check
	function automatic logic [3:0] owner_of(int q);
		return pool_owner[q];
	endfunction

	task automatic test_directed();
		// bad sizes, unknown modes, ops on free queue with owner zero
		send_item(mrmq_pkg::MODE_CREATE, 0, 0, 0, 0, 1);
		send_item(mrmq_pkg::MODE_CREATE, 0, 0, 0, 17, 1);
		send_item(mrmq_pkg::MODE_CREATE, 0, 0, 0, 31, 1);
		send_item(3'd5, 0, 0, 0, 1, 1);
		send_item(3'd7, 15, 15, 32'hFFFF_FFFF, 31, 0);
		send_item(mrmq_pkg::MODE_SEND, 3, 0, 1, 0, 1);
		send_item(mrmq_pkg::MODE_JAM, 3, 0, 1, 0, 0);
		send_item(mrmq_pkg::MODE_RECV, 3, 0, 0, 0, 1);
		send_item(mrmq_pkg::MODE_DESTROY, 3, 0, 0, 0, 0);
		send_item(mrmq_pkg::MODE_SEND, 3, 9, 1, 0, 1);
		// size 1 and 16 rings, full/empty, wrap
		send_item(mrmq_pkg::MODE_CREATE, 0, 15, 0, 1, 1);
		send_item(mrmq_pkg::MODE_CREATE, 0, 5, 0, 16, 1);
		send_item(mrmq_pkg::MODE_SEND, 0, 15, 32'hFFFF_FFFF, 0, 1);
		send_item(mrmq_pkg::MODE_SEND, 0, 15, 32'h1, 0, 1);
		send_item(mrmq_pkg::MODE_SEND, 0, 15, 32'h1, 0, 0);
		send_item(mrmq_pkg::MODE_RECV, 0, 15, 0, 0, 1);
		send_item(mrmq_pkg::MODE_RECV, 0, 15, 0, 0, 1);
		send_item(mrmq_pkg::MODE_RECV, 0, 15, 0, 0, 0);
		send_item(mrmq_pkg::MODE_JAM, 1, 5, 32'hA5A5_5A5A, 0, 1);
		send_item(mrmq_pkg::MODE_SEND, 1, 5, 32'h0000_0000, 0, 1);
		send_item(mrmq_pkg::MODE_RECV, 1, 5, 0, 0, 1);
		send_item(mrmq_pkg::MODE_RECV, 1, 4, 0, 0, 1);
		send_item(mrmq_pkg::MODE_DESTROY, 0, 15, 0, 0, 1);
		send_item(mrmq_pkg::MODE_DESTROY, 1, 5, 0, 0, 1);
		drain_results();
	endtask

	task automatic test_pool_exhaust();
		for (int i = 0; i < NQ + 2; i++) send_item(mrmq_pkg::MODE_CREATE, 0, 4'(i), 0, 2, 1);
		for (int i = 0; i < NQ; i++) send_item(mrmq_pkg::MODE_DESTROY, 4'(i), 4'(i), 0, 0, 1);
		drain_results();
	endtask

	task automatic test_random(int n);
		logic [2:0] m;
		logic [3:0] q, p;
		logic [4:0] sz;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			q = 4'($urandom_range(3));
			if (r < 8) q = 4'($urandom);
			p = (r < 90) ? owner_of(q) : 4'($urandom);
			r = $urandom_range(99);
			if (r < 12) m = mrmq_pkg::MODE_CREATE;
			else if (r < 42) m = mrmq_pkg::MODE_SEND;
			else if (r < 55) m = mrmq_pkg::MODE_JAM;
			else if (r < 88) m = mrmq_pkg::MODE_RECV;
			else if (r < 96) m = mrmq_pkg::MODE_DESTROY;
			else m = 3'($urandom_range(7, 5));
			sz = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(QD, 1));
			send_item(m, q, p, $urandom, sz, 1'($urandom));
		end
	endtask

	initial begin
		start = 0; mode = 0; queue_sel = 0; process_id = 0;
		message_in = 0; size_req = 0; no_wait = 0;
		for (int i = 0; i < NQ; i++) begin
			pool_cap[i] = 0; pool_head[i] = 0; pool_used[i] = 0; pool_owner[i] = 0;
		end
		arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_pool_exhaust();
		idle_pct = 7;
		test_random(310);
		drain_results();
		idle_pct = 58;
		test_random(310);
		drain_results();
		idle_pct = 0;
		test_random(310);
		drain_results();
		if (mismatches == 0 && pending_results.size() == 0 && !timed_out)
			$display("tb_multi_ring_message_queue_unit: done, clean");
		else
			$display("tb_multi_ring_message_queue_unit: done, errors");
		$finish;
	end

	initial begin
		wait (watchdog >= WATCHDOG_LIMIT);
		timed_out = 1;
		$display("tb_multi_ring_message_queue_unit: done, errors");
		$finish;
	end

endmodule

/* multi_ring_message_queue_unit.f */
design/mrmq_pkg.sv
design/mrmq_ram.sv
design/mrmq_ctrl.sv
design/mrmq_dp.sv
design/multi_ring_message_queue_unit.sv
tb/sv/tb_multi_ring_message_queue_unit.sv
